// ----- src/nae_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nae_pkg: shared types and constants of the normalize and affine element
// Payload structs of the three channels and the side data that travels next to
// the reciprocal square root pipeline.
// ----------------------------------------------------------------------------
package nae_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned SumWidth        = 33;  // variance plus epsilon
  localparam int unsigned ProdWidth       = 63;  // |scale| * |x - mean|
  localparam int unsigned CapBits         = 41;  // magnitude is capped at 2^40
  localparam logic [15:0] EpsilonReset    = 16'd1;

  typedef struct packed {
    logic signed [31:0] x_value;
    logic signed [31:0] mean_value;
    logic        [31:0] var_value;
    logic signed [31:0] scale_value;
    logic signed [31:0] bias_value;
  } nae_in_t;

  typedef struct packed {
    logic signed [31:0] y_value;
    logic               clipped;
  } nae_out_t;

  typedef struct packed {
    logic [15:0] epsilon;
  } nae_cfg_t;

  // Data that rides along with the square root stages.
  typedef struct packed {
    logic [ProdWidth-1:0] pm;
    logic                 neg;
    logic signed [31:0]   bias;
    logic                 zero;
  } nae_carry_t;

endpackage
`default_nettype wire

// ----- src/nae_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nae_stream_if: valid/ready channel
// One transfer happens at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface nae_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/nae_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nae_front: input register and operand preparation
// Forms var+epsilon, the sign and the magnitudes of scale and x-mean into the
// input register, then the exact magnitude of scale*(x-mean).
// ----------------------------------------------------------------------------
module nae_front import nae_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire logic                valid_i,
  input  wire nae_in_t             data_i,
  input  wire logic [15:0]         eps_i,
  output logic                     valid_o,
  output logic [SumWidth-1:0]      s_o,
  output nae_carry_t               carry_o
);

  logic                in_valid_q;
  logic [31:0]         am_q;
  logic [31:0]         dm_q;
  logic                neg_q;
  logic [SumWidth-1:0] s_q;
  logic signed [31:0]  bias_q;

  logic signed [32:0]   d;
  logic        [31:0]   am_d;
  logic        [31:0]   dm_d;
  logic                 neg_d;
  logic [SumWidth-1:0]  s_d;
  logic        [63:0]   pm_full;
  nae_carry_t           carry_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      valid_o    <= 1'b0;
    end else if (adv_i) begin
      in_valid_q <= valid_i;
      valid_o    <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      am_q    <= am_d;
      dm_q    <= dm_d;
      neg_q   <= neg_d;
      s_q     <= s_d;
      bias_q  <= data_i.bias_value;
      s_o     <= s_q;
      carry_o <= carry_d;
    end
  end

  // The magnitude of x-mean is below 2^32, so it fits in 32 bits.
  always_comb begin
    d     = {data_i.x_value[31], data_i.x_value} - {data_i.mean_value[31], data_i.mean_value};
    am_d  = data_i.scale_value[31] ? 32'(-data_i.scale_value) : data_i.scale_value;
    dm_d  = d[32] ? 32'(-d) : d[31:0];
    neg_d = data_i.scale_value[31] ^ d[32];
    s_d   = SumWidth'(data_i.var_value) + SumWidth'(eps_i);
  end

  always_comb begin
    pm_full      = 64'(am_q) * 64'(dm_q);
    carry_d.pm   = pm_full[ProdWidth-1:0];
    carry_d.neg  = neg_q;
    carry_d.bias = bias_q;
    carry_d.zero = (s_q == '0);
  end

endmodule
`default_nettype wire

// ----- src/nae_rsqrt_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nae_rsqrt_stage: one bit of the reciprocal square root
// Tries to set bit BIT of r, keeping P = r*r*s and Q = r*s incrementally so
// the test is one three-input add and a compare against 2^(3*FRAC_BITS).
// ----------------------------------------------------------------------------
module nae_rsqrt_stage import nae_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault,
  parameter int unsigned BIT       = 0,
  localparam int unsigned RW       = (3 * FRAC_BITS) / 2 + 1,
  localparam int unsigned PW       = 3 * FRAC_BITS + 1,
  localparam int unsigned QW       = RW + SumWidth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire logic                valid_i,
  input  wire logic [SumWidth-1:0] s_i,
  input  wire logic [PW-1:0]       p_i,
  input  wire logic [QW-1:0]       q_i,
  input  wire logic [RW-1:0]       r_i,
  input  wire nae_carry_t          carry_i,
  output logic                     valid_o,
  output logic [SumWidth-1:0]      s_o,
  output logic [PW-1:0]            p_o,
  output logic [QW-1:0]            q_o,
  output logic [RW-1:0]            r_o,
  output nae_carry_t               carry_o
);

  localparam int unsigned CW = QW + RW + 2;

  logic [CW-1:0] cand;
  logic [CW-1:0] limit;
  logic          fit;

  always_comb begin
    cand  = CW'(p_i) + (CW'(q_i) << (BIT + 1)) + (CW'(s_i) << (2 * BIT));
    limit = CW'(1) << (3 * FRAC_BITS);
    fit   = (cand <= limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s_o     <= s_i;
      carry_o <= carry_i;
      if (fit) begin
        p_o <= cand[PW-1:0];
        q_o <= q_i + (QW'(s_i) << BIT);
        r_o <= r_i | (RW'(1) << BIT);
      end else begin
        p_o <= p_i;
        q_o <= q_i;
        r_o <= r_i;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/nae_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nae_back: scaling by the reciprocal square root and output stage
// Partial products, their sum, then shift, cap, sign, bias and saturation into
// the output register; a zero denominator passes the bias through as clipped.
// ----------------------------------------------------------------------------
module nae_back import nae_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault,
  localparam int unsigned RW       = (3 * FRAC_BITS) / 2 + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          valid_i,
  input  wire logic [RW-1:0] r_i,
  input  wire nae_carry_t    carry_i,
  output logic               valid_o,
  output nae_out_t           data_o
);

  localparam logic [CapBits-1:0] Cap = CapBits'(1) << (CapBits - 1);

  logic          valid_p_q, valid_s_q;
  nae_carry_t    c_p_q, c_s_q;
  logic [63:0]   p00_q, p01_q, p10_q, p11_q;
  logic [127:0]  full_q;
  logic          zero_o_q;
  logic [31:0]   bias_o_q;

  logic [63:0]          pm64, r64;
  logic [127:0]         full_d, shifted;
  logic [CapBits-1:0]   t;
  logic signed [41:0]   v;
  logic signed [42:0]   sum;
  nae_out_t             out_d;

  always_comb begin
    pm64 = 64'(carry_i.pm);
    r64  = 64'(r_i);
  end

  always_comb begin
    full_d = 128'(p00_q) + (128'(p01_q) << 32) + (128'(p10_q) << 32) + (128'(p11_q) << 64);
  end

  always_comb begin
    shifted = full_q >> (2 * FRAC_BITS);
    t       = (shifted > 128'(Cap)) ? Cap : shifted[CapBits-1:0];
    v       = c_s_q.neg ? -$signed({1'b0, t}) : $signed({1'b0, t});
    sum     = {v[41], v} + {{11{c_s_q.bias[31]}}, c_s_q.bias};
    if (c_s_q.zero) begin
      out_d.y_value = c_s_q.bias;
      out_d.clipped = 1'b1;
    end else if (sum > 43'sd2147483647) begin
      out_d.y_value = 32'sh7fffffff;
      out_d.clipped = 1'b1;
    end else if (sum < -43'sd2147483648) begin
      out_d.y_value = 32'sh80000000;
      out_d.clipped = 1'b1;
    end else begin
      out_d.y_value = sum[31:0];
      out_d.clipped = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_p_q <= 1'b0;
      valid_s_q <= 1'b0;
      valid_o   <= 1'b0;
    end else if (adv_i) begin
      valid_p_q <= valid_i;
      valid_s_q <= valid_p_q;
      valid_o   <= valid_s_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_p_q    <= carry_i;
      p00_q    <= 64'(pm64[31:0])  * 64'(r64[31:0]);
      p01_q    <= 64'(pm64[31:0])  * 64'(r64[63:32]);
      p10_q    <= 64'(pm64[63:32]) * 64'(r64[31:0]);
      p11_q    <= 64'(pm64[63:32]) * 64'(r64[63:32]);
      c_s_q    <= c_p_q;
      full_q   <= full_d;
      data_o   <= out_d;
      zero_o_q <= c_s_q.zero;
      bias_o_q <= c_s_q.bias;
    end
  end

  // A stalled pipeline must hold its result.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(valid_o) && $stable(valid_s_q) && $stable(valid_p_q))
    else $error("back stages moved during a stall");

  a_zero_bias: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_o_q |-> data_o.clipped && (data_o.y_value == bias_o_q))
    else $error("zero denominator did not pass the bias through");

  a_clip_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && data_o.clipped && !zero_o_q |->
      (data_o.y_value == 32'sh7fffffff) || (data_o.y_value == 32'sh80000000))
    else $error("clipped result is not a saturation value");

endmodule
`default_nettype wire

// ----- src/normalize_affine_element.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// normalize_affine_element: y = a*(x-mean)/sqrt(var+epsilon) + b
// Fixed-point layer normalization of one element per transfer.
// ----------------------------------------------------------------------------
// The block takes one element per clock while the output is not stalled and
// returns one result per element in order. The pipeline has two input and
// operand stages, one stage per bit of the reciprocal square root, which is
// found a bit at a time, and three stages for the product, its sum and the
// bias/saturation output register. A stall at the output freezes the whole
// pipeline. epsilon resets to 1 and should be written only while the pipeline
// is empty; its write channel is always ready.
module normalize_affine_element import nae_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  nae_stream_if.sink   in_i,
  nae_stream_if.sink   cfg_i,
  nae_stream_if.source out_o
);

  localparam int unsigned RW = (3 * FRAC_BITS) / 2 + 1;
  localparam int unsigned PW = 3 * FRAC_BITS + 1;
  localparam int unsigned QW = RW + SumWidth;

  logic        adv;
  logic [15:0] eps_q;

  logic                valid_w [RW+1];
  logic [SumWidth-1:0] s_w     [RW+1];
  logic [PW-1:0]       p_w     [RW+1];
  logic [QW-1:0]       q_w     [RW+1];
  logic [RW-1:0]       r_w     [RW+1];
  nae_carry_t          carry_w [RW+1];

  assign adv         = !out_o.valid || out_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsilonReset;
    end else if (cfg_i.valid) begin
      eps_q <= cfg_i.data.epsilon;
    end
  end

  nae_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_i.valid),
    .data_i  (in_i.data),
    .eps_i   (eps_q),
    .valid_o (valid_w[0]),
    .s_o     (s_w[0]),
    .carry_o (carry_w[0])
  );

  assign p_w[0] = '0;
  assign q_w[0] = '0;
  assign r_w[0] = '0;

  for (genvar i = 0; i < RW; i++) begin : g_rsqrt
    nae_rsqrt_stage #(
      .FRAC_BITS (FRAC_BITS),
      .BIT       (RW - 1 - i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_w[i]),
      .s_i     (s_w[i]),
      .p_i     (p_w[i]),
      .q_i     (q_w[i]),
      .r_i     (r_w[i]),
      .carry_i (carry_w[i]),
      .valid_o (valid_w[i+1]),
      .s_o     (s_w[i+1]),
      .p_o     (p_w[i+1]),
      .q_o     (q_w[i+1]),
      .r_o     (r_w[i+1]),
      .carry_o (carry_w[i+1])
    );
  end

  nae_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (valid_w[RW]),
    .r_i     (r_w[RW]),
    .carry_i (carry_w[RW]),
    .valid_o (out_o.valid),
    .data_o  (out_o.data)
  );

endmodule
`default_nettype wire

// ----- sim/tb_normalize_affine_element.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_normalize_affine_element: self-checking bench for the normalize element
// Drives elements with random gaps and output stalls, predicts each result
// with a bit-exact reciprocal square root and affine model, and compares every
// output transfer in order against the predicted y and clip flag.
// ----------------------------------------------------------------------------
module tb_normalize_affine_element;
  import nae_pkg::*;

  localparam int unsigned LatencyCycles = 3 * FracBitsDefault / 2 + 6;
  localparam int unsigned CycleLimit    = 600000;

  class norm_result_board;
    logic [15:0] epsilon;
    nae_out_t    expected_y[$];
    int          mismatches;
    int          checked;
    int          clipped_seen;

    function new();
      epsilon = EpsilonReset;
      mismatches = 0;
      checked = 0;
      clipped_seen = 0;
    endfunction

    // Largest r with r*r*s <= 2^48, found one bit at a time.
    function logic [37:0] inv_sqrt(logic [33:0] s);
      logic [37:0]  r;
      logic [37:0]  c;
      logic [127:0] q;
      r = '0;
      for (int k = 37; k >= 0; k--) begin
        c = r | (38'd1 << k);
        q = 128'(c) * 128'(c) * 128'(s);
        if (q <= (128'd1 << (3 * FracBitsDefault))) r = c;
      end
      return r;
    endfunction

    function nae_out_t normalize(nae_in_t it);
      logic [33:0]     s;
      logic [37:0]     r;
      longint          d;
      longint          a;
      longint unsigned am;
      longint unsigned dm;
      logic [127:0]    prod;
      logic [127:0]    t;
      longint          v;
      longint          sum;
      bit              neg;
      nae_out_t        o;
      s = 34'(it.var_value) + 34'(epsilon);
      if (s == 0) begin
        o.y_value = it.bias_value;
        o.clipped = 1'b1;
        return o;
      end
      r = inv_sqrt(s);
      d = longint'(it.x_value) - longint'(it.mean_value);
      a = longint'(it.scale_value);
      am = (a < 0) ? -a : a;
      dm = (d < 0) ? -d : d;
      neg = (a < 0) != (d < 0);
      prod = 128'(am * dm) * 128'(r);
      t = prod >> (2 * FracBitsDefault);
      if (t > (128'd1 << 40)) t = 128'd1 << 40;
      v = neg ? -longint'(t[63:0]) : longint'(t[63:0]);
      sum = v + longint'(it.bias_value);
      o.clipped = 1'b0;
      if (sum > 64'sd2147483647) begin
        sum = 64'sd2147483647;
        o.clipped = 1'b1;
      end else if (sum < -64'sd2147483648) begin
        sum = -64'sd2147483648;
        o.clipped = 1'b1;
      end
      o.y_value = sum[31:0];
      return o;
    endfunction

    function void note_element(nae_in_t it);
      expected_y.push_back(normalize(it));
    endfunction

    function void check_result(nae_out_t got);
      nae_out_t want;
      if (expected_y.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result y=%0d clipped=%0b", got.y_value, got.clipped);
        return;
      end
      want = expected_y.pop_front();
      checked++;
      if (want.clipped) clipped_seen++;
      if (got.y_value !== want.y_value || got.clipped !== want.clipped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d expected y=%0d clipped=%0b, got y=%0d clipped=%0b",
                   checked, want.y_value, want.clipped, got.y_value, got.clipped);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   send_idle;
  int   recv_idle;
  int   hold_cycles;
  bit   hold_request;
  int   sent;

  norm_result_board board;

  nae_stream_if #(.payload_t(nae_in_t))  in_if ();
  nae_stream_if #(.payload_t(nae_cfg_t)) cfg_if ();
  nae_stream_if #(.payload_t(nae_out_t)) out_if ();

  normalize_affine_element dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) board.check_result(out_if.data);
    if (hold_request) begin
      hold_request = 1'b0;
      hold_cycles = 300;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_element(nae_in_t it);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk); while (!in_if.ready);
    board.note_element(it);
    sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.expected_y.size() != 0) @(posedge clk);
    repeat (LatencyCycles + 10) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [15:0] eps);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data.epsilon <= eps;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    board.epsilon = eps;
  endtask

  function automatic logic [31:0] pick_signed();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      2: return 32'($signed($urandom_range(0, 2 ** 27)) - 2 ** 26);
      3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17);
    endcase
  endfunction

  function automatic logic [31:0] pick_variance();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return $urandom_range(0, 1000);
      2: return $urandom_range(0, 2 ** 20);
      3: return $urandom_range(1) ? 32'hffff_ffff : 32'hffff_0000 + $urandom_range(65535);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int count);
    nae_in_t it;
    for (int i = 0; i < count; i++) begin
      it.x_value = pick_signed();
      it.mean_value = pick_signed();
      it.var_value = pick_variance();
      it.scale_value = pick_signed();
      it.bias_value = pick_signed();
      send_element(it);
    end
  endtask

  task automatic send_directed();
    nae_in_t it;
    it = '{32'sh0001_0000, 32'sh0, 32'h0001_0000, 32'sh0001_0000, 32'sh0};
    send_element(it);
    it = '{32'sh7fff_ffff, 32'sh8000_0000, 32'h0, 32'sh7fff_ffff, 32'sh7fff_ffff};
    send_element(it);
    it = '{32'sh8000_0000, 32'sh7fff_ffff, 32'h0, 32'sh7fff_ffff, 32'sh8000_0000};
    send_element(it);
    it = '{32'sh8000_0000, 32'sh7fff_ffff, 32'hffff_ffff, 32'sh8000_0000, 32'sh0};
    send_element(it);
    it = '{32'sh0003_0000, 32'sh0001_0000, 32'h0004_0000, 32'shffff_0000, 32'sh0000_8000};
    send_element(it);
    it = '{32'sh1234_5678, 32'sh1234_5678, 32'h0, 32'sh7fff_ffff, 32'sh8000_0000};
    send_element(it);
    it = '{32'shfffe_0000, 32'sh0001_0000, 32'h0000_0001, 32'sh0001_0000, 32'sh7fff_0000};
    send_element(it);
    it = '{32'sh0, 32'sh0, 32'hffff_ffff, 32'sh0, 32'sh7fff_ffff};
    send_element(it);
  endtask

  initial begin
    int failures;
    board = new();
    cycles = 0;
    sent = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_cycles = 0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset epsilon, then epsilon zero so a zero variance has no denominator, then 0xffff.
    send_directed();
    write_epsilon(16'd0);
    send_directed();
    write_epsilon(16'hffff);
    send_directed();

    send_idle = 37;
    recv_idle = 57;
    send_random(170);

    write_epsilon(16'($urandom_range(2, 65534)));
    send_idle = 57;
    recv_idle = 37;
    send_random(170);

    write_epsilon(16'd0);
    send_idle = 0;
    recv_idle = 0;
    send_random(60);
    hold_request = 1'b1;
    send_random(60);
    // Let the pipeline empty before the last burst.
    drain();
    write_epsilon(16'd1);
    send_random(65);

    drain();
    failures = board.mismatches + board.expected_y.size();
    $display("Checked %0d results from %0d elements, %0d of them clipped,",
             board.checked, sent, board.clipped_seen);
    $display("over six epsilon phases with random gaps, stalls and a long hold-off.");
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", failures);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
